// ----- rtl/bpld_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpld_pkg
// Shared widths, codes and types of the button press / long-press detector.
// ----------------------------------------------------------------------------
package bpld_pkg;

    // Field widths
    localparam int BTN_W      = 3;
    localparam int KIND_W     = 2;
    localparam int TIME_W     = 16;
    localparam int PERIOD_W   = 8;
    localparam int MASK_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Buttons in use and slots in the state memory
    localparam int NUM_BUTTONS = 8;
    localparam int NUM_SLOTS   = 2 ** BTN_W;

    // Event queue depth: one beat in the output stage, one leaving, one in flight
    localparam int EVQ_DEPTH = 3;

    // Register reset values
    localparam logic [MASK_W-1:0]   RST_ACTIVE_LOW_MASK = 8'd255;
    localparam logic [PERIOD_W-1:0] RST_POLL_PERIOD     = 8'd5;
    localparam logic [TIME_W-1:0]   RST_PRESS_THR       = 16'd50;
    localparam logic [TIME_W-1:0]   RST_LONG_THR        = 16'd3000;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LOW_MASK = 2'd0,
        CFG_POLL_PERIOD     = 2'd1,
        CFG_PRESS_THR       = 2'd2,
        CFG_LONG_THR        = 2'd3
    } cfg_idx_e;

    // Event codes
    typedef enum logic [KIND_W-1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_LONG    = 2'd2
    } ev_kind_e;

    // Which event a held button last sent
    typedef enum logic [1:0] {
        SENT_NONE  = 2'd0,
        SENT_PRESS = 2'd1,
        SENT_LONG  = 2'd2
    } sent_e;

    // One button's entry in the state memory
    typedef struct packed {
        logic              held;
        logic [TIME_W-1:0] held_time;
        sent_e             sent;
    } entry_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [MASK_W-1:0]   active_low_mask;
        logic [PERIOD_W-1:0] poll_period;
        logic [TIME_W-1:0]   press_thr;
        logic [TIME_W-1:0]   long_thr;
    } cfg_t;

    // Event beat from the update stage to the event queue
    typedef struct packed {
        logic             valid;
        logic [BTN_W-1:0] button_id;
        ev_kind_e         event_kind;
    } evt_t;

endpackage
`default_nettype wire

// ----- rtl/bpld_intf.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpld_smp_if / bpld_evt_if
// Valid/ready channels: poll samples in, button events out.
// ----------------------------------------------------------------------------
interface bpld_smp_if;
    logic                          valid;
    logic                          ready;
    logic [bpld_pkg::BTN_W-1:0]    button_index;
    logic                          pin_level;

    modport source (output valid, output button_index, output pin_level, input ready);
    modport sink   (input valid, input button_index, input pin_level, output ready);
endinterface

interface bpld_evt_if;
    logic                          valid;
    logic                          ready;
    logic [bpld_pkg::BTN_W-1:0]    button_id;
    logic [bpld_pkg::KIND_W-1:0]   event_kind;

    modport source (output valid, output button_id, output event_kind, input ready);
    modport sink   (input valid, input button_id, input event_kind, output ready);
endinterface
`default_nettype wire

// ----- rtl/button_press_long_press_detector_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// button_press_long_press_detector_unit
// Per-button press, release and long-press detection from poll samples.
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  smp       in   button_index[2:0], pin_level
//  evt       out  button_id[2:0], event_kind[1:0] (press, release, long)
//  cfg_*     in   cfg_we, cfg_index[1:0], cfg_wdata[15:0]
//
//  One sample per cycle while the event queue has room; an event passes the update
//  stage and the event queue before it is offered. The per-button state RAM is read
//  at accept and written back in the cycle after; the last write is forwarded, so
//  samples of one button may follow back to back. Reset clears all per-button state
//  at once through entry valid bits. A stalled event channel holds samples off once
//  queued and in-flight events fill the three-beat queue.
module button_press_long_press_detector_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    bpld_smp_if.sink                               smp,
    bpld_evt_if.source                             evt,
    input  wire logic                              cfg_we,
    input  wire logic [bpld_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bpld_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    bpld_pkg::cfg_t cfg_reg;
    bpld_pkg::evt_t ev;
    logic           busy;
    logic           can_accept;
    logic           in_fire;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_low_mask <= bpld_pkg::RST_ACTIVE_LOW_MASK;
            cfg_reg.poll_period     <= bpld_pkg::RST_POLL_PERIOD;
            cfg_reg.press_thr       <= bpld_pkg::RST_PRESS_THR;
            cfg_reg.long_thr        <= bpld_pkg::RST_LONG_THR;
        end
        else if (cfg_we)
        begin
            case (bpld_pkg::cfg_idx_e'(cfg_index))
                bpld_pkg::CFG_ACTIVE_LOW_MASK:
                    cfg_reg.active_low_mask <= cfg_wdata[bpld_pkg::MASK_W-1:0];
                bpld_pkg::CFG_POLL_PERIOD:
                    cfg_reg.poll_period <= cfg_wdata[bpld_pkg::PERIOD_W-1:0];
                bpld_pkg::CFG_PRESS_THR:
                    cfg_reg.press_thr <= cfg_wdata[bpld_pkg::TIME_W-1:0];
                bpld_pkg::CFG_LONG_THR:
                    cfg_reg.long_thr <= cfg_wdata[bpld_pkg::TIME_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Sample handshake
    assign smp.ready = can_accept;
    assign in_fire   = smp.valid && can_accept;

    bpld_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_index (smp.button_index),
        .in_level (smp.pin_level),
        .cfg      (cfg_reg),
        .ev       (ev),
        .busy     (busy)
    );

    bpld_evq u_evq (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (ev),
        .reserve        (busy),
        .can_accept     (can_accept),
        .out_valid      (evt.valid),
        .out_ready      (evt.ready),
        .out_button_id  (evt.button_id),
        .out_event_kind (evt.event_kind)
    );

endmodule
`default_nettype wire

// ----- rtl/bpld_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpld_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and read port; a read of the entry being written sees old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- rtl/bpld_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpld_core
// Per-button state memory and the read-modify-write update stage.
// ----------------------------------------------------------------------------
module bpld_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_fire,
    input  wire logic [bpld_pkg::BTN_W-1:0] in_index,
    input  wire logic                       in_level,
    input  wire bpld_pkg::cfg_t             cfg,
    output bpld_pkg::evt_t                  ev,
    output logic                            busy
);

    localparam int ENTRY_W = $bits(bpld_pkg::entry_t);

    // Update stage
    logic                       s1_valid_reg;
    logic [bpld_pkg::BTN_W-1:0] s1_idx_reg;
    logic                       s1_level_reg;

    // Entry valid bits: an unwritten entry reads as the reset entry
    logic [bpld_pkg::NUM_SLOTS-1:0] vld_reg;
    logic [bpld_pkg::NUM_SLOTS-1:0] vld_next;

    // Forwarding of the entry written at the last edge
    logic                       fwd_valid_reg;
    logic [bpld_pkg::BTN_W-1:0] fwd_idx_reg;
    bpld_pkg::entry_t           fwd_data_reg;

    logic [ENTRY_W-1:0]         ram_rdata;
    bpld_pkg::entry_t           rd_entry;
    bpld_pkg::entry_t           cur;
    bpld_pkg::entry_t           nxt;
    logic                       in_range;
    logic                       fwd_hit;
    logic                       pressed;
    logic [bpld_pkg::TIME_W:0]  sum;
    logic [bpld_pkg::TIME_W-1:0] t_new;
    logic                       wr_en;

    bpld_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (bpld_pkg::NUM_SLOTS)
    ) u_state_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_idx_reg),
        .wdata (nxt),
        .re    (in_fire),
        .raddr (in_index),
        .rdata (ram_rdata)
    );

    assign rd_entry = bpld_pkg::entry_t'(ram_rdata);

    // Stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= in_fire;
            fwd_valid_reg <= wr_en;
            vld_reg       <= vld_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_idx_reg   <= in_index;
            s1_level_reg <= in_level;
        end
        if (wr_en)
        begin
            fwd_idx_reg  <= s1_idx_reg;
            fwd_data_reg <= nxt;
        end
    end

    // Current entry: last write wins over the memory, invalid reads as reset
    always_comb
    begin
        fwd_hit = fwd_valid_reg && (fwd_idx_reg == s1_idx_reg);
        if (fwd_hit)
        begin
            cur = fwd_data_reg;
        end
        else if (vld_reg[s1_idx_reg])
        begin
            cur = rd_entry;
        end
        else
        begin
            cur = '0;
        end
    end

    // Hold timer update and event decision
    always_comb
    begin
        in_range = {1'b0, s1_idx_reg} < (bpld_pkg::BTN_W + 1)'(bpld_pkg::NUM_BUTTONS);
        pressed  = s1_level_reg ^ cfg.active_low_mask[s1_idx_reg];
        sum      = {1'b0, cur.held_time}
                 + (bpld_pkg::TIME_W + 1)'(cfg.poll_period);
        t_new    = sum[bpld_pkg::TIME_W] ? bpld_pkg::TIME_MAX : sum[bpld_pkg::TIME_W-1:0];

        nxt           = cur;
        ev.valid      = 1'b0;
        ev.button_id  = s1_idx_reg;
        ev.event_kind = bpld_pkg::EV_PRESS;

        if (pressed)
        begin
            if (!cur.held)
            begin
                // first pressed sample starts the hold
                nxt.held      = 1'b1;
                nxt.held_time = '0;
                nxt.sent      = bpld_pkg::SENT_NONE;
            end
            else
            begin
                nxt.held_time = t_new;
                if (t_new >= cfg.long_thr)
                begin
                    if (cur.sent != bpld_pkg::SENT_LONG)
                    begin
                        nxt.sent      = bpld_pkg::SENT_LONG;
                        ev.valid      = s1_valid_reg && in_range;
                        ev.event_kind = bpld_pkg::EV_LONG;
                    end
                end
                else if (t_new >= cfg.press_thr)
                begin
                    if (cur.sent == bpld_pkg::SENT_NONE)
                    begin
                        nxt.sent      = bpld_pkg::SENT_PRESS;
                        ev.valid      = s1_valid_reg && in_range;
                        ev.event_kind = bpld_pkg::EV_PRESS;
                    end
                end
            end
        end
        else if (cur.held)
        begin
            // release: report only after a plain press
            nxt = '0;
            if (cur.sent == bpld_pkg::SENT_PRESS)
            begin
                ev.valid      = s1_valid_reg && in_range;
                ev.event_kind = bpld_pkg::EV_RELEASE;
            end
        end

        wr_en = s1_valid_reg && in_range;

        vld_next = vld_reg;
        if (wr_en)
        begin
            vld_next[s1_idx_reg] = 1'b1;
        end
    end

    assign busy = s1_valid_reg;

`ifndef SYNTH
    // A release beat only follows a plain press of a held button
    a_release_after_press: assert property (@(posedge clk) disable iff (!rst_n)
        (ev.valid && ev.event_kind == bpld_pkg::EV_RELEASE)
            |-> (cur.held && cur.sent == bpld_pkg::SENT_PRESS))
        else $error("release event without a pending press");

    // Every event goes with a state write-back
    a_event_writes: assert property (@(posedge clk) disable iff (!rst_n)
        ev.valid |-> wr_en)
        else $error("event without state update");

    // Forwarding entry only exists after an update stage beat
    a_fwd_origin: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> $past(s1_valid_reg))
        else $error("forwarding register set without an update");

    // Back-to-back samples of one button see the forwarded entry
    a_fwd_same_button: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && fwd_valid_reg && fwd_idx_reg == s1_idx_reg) |-> (cur == fwd_data_reg))
        else $error("stale entry used for a back-to-back sample");
`endif

endmodule
`default_nettype wire

// ----- rtl/bpld_evq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpld_evq
// Small event queue between the update stage and the event channel.
// ----------------------------------------------------------------------------
module bpld_evq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bpld_pkg::evt_t              push,
    input  wire logic                        reserve,
    output logic                             can_accept,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [bpld_pkg::BTN_W-1:0]       out_button_id,
    output logic [bpld_pkg::KIND_W-1:0]      out_event_kind
);

    localparam int PTR_W = (bpld_pkg::EVQ_DEPTH > 1) ? $clog2(bpld_pkg::EVQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(bpld_pkg::EVQ_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(bpld_pkg::EVQ_DEPTH - 1);

    bpld_pkg::evt_t   slot_reg [bpld_pkg::EVQ_DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    // Pointer and fill count update
    always_comb
    begin
        pop        = out_valid && out_ready;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next = (head_reg == LAST) ? '0 : head_reg + PTR_W'(1);
        end
        if (push.valid)
        begin
            tail_next = (tail_reg == LAST) ? '0 : tail_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push.valid) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[tail_reg] <= push;
        end
    end

    // Room for a new sample: queued beats plus the one in flight must leave a slot
    assign can_accept = ((CNT_W + 1)'(count_reg) + (CNT_W + 1)'(reserve))
                      < (CNT_W + 1)'(bpld_pkg::EVQ_DEPTH);

    assign out_valid      = (count_reg != '0);
    assign out_button_id  = slot_reg[head_reg].button_id;
    assign out_event_kind = slot_reg[head_reg].event_kind;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(bpld_pkg::EVQ_DEPTH))
        else $error("event queue overfilled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (count_reg < CNT_W'(bpld_pkg::EVQ_DEPTH)))
        else $error("event pushed into a full queue");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push.valid) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("fill count not reduced by a pop");
`endif

endmodule
`default_nettype wire
